// ----- src/set_assoc_cache_with_prefetch_core_macros.svh -----
`ifndef SET_ASSOC_CACHE_WITH_PREFETCH_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_WITH_PREFETCH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/scp_pkg.sv -----
package scp_pkg;

    localparam int ADDR_BITS = 48;
    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 8;
    localparam int DEF_MAX_PREFETCH = 15;
    localparam int STAMP_W = 32;
    localparam int CNT_W = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [3:0] BLOCK_BITS_MAX = 4'd12;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_COUNT = 3'd4;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 is_write;
    } in_t;

    typedef struct packed {
        logic             hit;
        logic [4:0]       reads_issued;
        logic [CNT_W-1:0] total_hits;
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_reads;
        logic [CNT_W-1:0] total_writes;
    } out_t;

    typedef struct packed {
        logic [3:0] block_bits;
        logic [3:0] set_bits;
        logic [3:0] ways_used;
        logic       lru_mode;
        logic [3:0] prefetch_count;
    } cfg_t;

endpackage

// ----- src/scp_front.sv -----
module scp_front
    import scp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  item,
    input  logic clearing,
    input  logic pop,
    output logic busy,
    output logic q_valid,
    output in_t  q_item
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    in_t            q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           push;

    assign busy    = (count_reg == QCW'(QUEUE_DEPTH)) || clearing;
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- src/scp_back.sv -----
module scp_back
    import scp_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    parameter int MAX_PREFETCH = DEF_MAX_PREFETCH
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  in_t  q_item,
    output logic pop,
    output logic clearing,
    output logic done,
    output out_t result
);

    localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WCW = ($clog2(MAX_WAYS + 1) > 4) ? $clog2(MAX_WAYS + 1) : 4;
    localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int PFW = (MAX_PREFETCH > 0) ? $clog2(MAX_PREFETCH + 1) : 1;
    localparam int ENT_W = 1 + ADDR_BITS + STAMP_W;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EV   = 2'd3;

    logic [MAX_WAYS-1:0][ENT_W-1:0] row_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][ENT_W-1:0] rd_row_reg;
    logic [MAX_WAYS-1:0][ENT_W-1:0] wr_row;
    logic                           mem_we, mem_re;
    logic [SIW-1:0]                 wr_idx;

    logic [1:0]           state_reg, state_next;
    logic [SIW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] tag_reg, tag_next;
    logic [SIW-1:0]       set_reg, set_next;
    logic                 demand_reg, demand_next;
    logic                 hit_reg, hit_next;
    logic [PFW-1:0]       pf_left_reg, pf_left_next;
    logic [4:0]           issued_reg, issued_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic [CNT_W-1:0]     misses_reg, misses_next;
    logic [CNT_W-1:0]     reads_reg, reads_next;
    logic [CNT_W-1:0]     writes_reg, writes_next;
    logic                 done_reg, done_next;
    out_t                 result_reg, result_next;

    logic [3:0]           bb, sb;
    logic [WCW-1:0]       eff_ways;
    logic [PFW-1:0]       npf;
    logic [ADDR_BITS-1:0] blk, tag_c;
    logic [SIW-1:0]       set_c;

    assign bb = (cfg.block_bits > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : cfg.block_bits;
    assign sb = (32'(cfg.set_bits) > SB_MAX) ? 4'(SB_MAX) : cfg.set_bits;
    assign eff_ways = (cfg.ways_used == 4'd0) ? WCW'(1)
                    : (32'(cfg.ways_used) > MAX_WAYS) ? WCW'(MAX_WAYS)
                    : WCW'(cfg.ways_used);
    assign npf = (32'(cfg.prefetch_count) > MAX_PREFETCH) ? PFW'(MAX_PREFETCH)
               : PFW'(cfg.prefetch_count);
    assign blk   = addr_reg >> bb;
    assign tag_c = blk >> sb;
    assign set_c = blk[SIW-1:0] & ~({SIW{1'b1}} << sb);

    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign clearing = (state_reg == S_CLR);
    assign done     = done_reg;
    assign result   = result_reg;

    always_comb
    begin
        logic [WIW-1:0]     hit_way;
        logic [WIW-1:0]     place;
        logic               hit_c;
        logic               found;
        logic               more;
        logic [STAMP_W-1:0] fstamp;
        logic [STAMP_W-1:0] oldest;
        logic [STAMP_W-1:0] base;
        logic [ENT_W-1:0]   ent;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        tag_next     = tag_reg;
        set_next     = set_reg;
        demand_next  = demand_reg;
        hit_next     = hit_reg;
        pf_left_next = pf_left_reg;
        issued_next  = issued_reg;
        stamp_next   = stamp_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        reads_next   = reads_reg;
        writes_next  = writes_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        wr_idx       = set_reg;
        wr_row       = rd_row_reg;

        hit_way = '0;
        hit_c   = 1'b0;
        place   = '0;
        found   = 1'b0;
        more    = 1'b0;
        fstamp  = demand_reg ? stamp_reg : stamp_reg + 1'b1;
        oldest  = fstamp;
        base    = stamp_reg;
        ent     = '0;

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            ent = rd_row_reg[w];
            if (WCW'(w) < eff_ways && !hit_c && ent[ENT_W-1]
                && ent[ENT_W-2 -: ADDR_BITS] == tag_reg)
            begin
                hit_c   = 1'b1;
                hit_way = WIW'(w);
            end
        end
        // Victim: first invalid way, else the way with the strictly oldest stamp.
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            ent = rd_row_reg[w];
            if (WCW'(w) < eff_ways && !found)
            begin
                if (!ent[ENT_W-1])
                begin
                    place = WIW'(w);
                    found = 1'b1;
                end
                else if (ent[STAMP_W-1:0] < oldest)
                begin
                    oldest = ent[STAMP_W-1:0];
                    place  = WIW'(w);
                end
            end
        end

        case (state_reg)
            S_CLR:
            begin
                mem_we       = 1'b1;
                wr_idx       = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SIW'(MAX_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    addr_next    = q_item.address;
                    writes_next  = writes_reg + CNT_W'(q_item.is_write);
                    stamp_next   = stamp_reg + 1'b1;
                    pf_left_next = npf;
                    issued_next  = '0;
                    demand_next  = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                tag_next   = tag_c;
                set_next   = set_c;
                state_next = S_EV;
            end
            S_EV:
            begin
                if (hit_c)
                begin
                    if (cfg.lru_mode)
                    begin
                        mem_we = 1'b1;
                        wr_row[hit_way][STAMP_W-1:0] = stamp_reg;
                    end
                end
                else
                begin
                    mem_we        = 1'b1;
                    wr_row[place] = {1'b1, tag_reg, fstamp};
                    issued_next   = issued_reg + 1'b1;
                    reads_next    = reads_reg + 1'b1;
                    base          = fstamp;
                end
                if (demand_reg)
                begin
                    hit_next = hit_c;
                    if (hit_c)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                    else
                    begin
                        misses_next = misses_reg + 1'b1;
                    end
                end
                more = !(demand_reg && hit_c) && (pf_left_reg != '0);
                if (more)
                begin
                    addr_next    = addr_reg + (ADDR_BITS'(1) << bb);
                    pf_left_next = pf_left_reg - 1'b1;
                    demand_next  = 1'b0;
                    stamp_next   = base + 1'b1;
                    state_next   = S_RD;
                end
                else
                begin
                    stamp_next                = base;
                    done_next                 = 1'b1;
                    result_next.hit           = demand_reg ? hit_c : hit_reg;
                    result_next.reads_issued  = issued_next;
                    result_next.total_hits    = hits_next;
                    result_next.total_misses  = misses_next;
                    result_next.total_reads   = reads_next;
                    result_next.total_writes  = writes_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            stamp_reg   <= STAMP_W'(1);
            hits_reg    <= '0;
            misses_reg  <= '0;
            reads_reg   <= '0;
            writes_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            stamp_reg   <= stamp_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            reads_reg   <= reads_next;
            writes_reg  <= writes_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        tag_reg     <= tag_next;
        set_reg     <= set_next;
        demand_reg  <= demand_next;
        hit_reg     <= hit_next;
        pf_left_reg <= pf_left_next;
        issued_reg  <= issued_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[wr_idx] <= wr_row;
        end
        if (mem_re)
        begin
            rd_row_reg <= row_mem[set_c];
        end
    end

endmodule

// ----- src/set_assoc_cache_with_prefetch_core.sv -----
// Tag model of a set-associative cache with FIFO or LRU replacement and
// next-line prefetch after a demand miss.
// An access transaction is taken on a rising edge with start high and busy low.
// Accepted accesses wait in a two-entry queue in front of the lookup engine.
// The engine takes an access from the queue in its idle state; then each lookup
// reads one set row and evaluates it, writing the row back on a miss or, in LRU
// mode, on a hit. A demand hit ends the access; a demand miss is followed by
// one next-line prefetch lookup per configured prefetch. The engine takes no
// new access before it is done with the last one. done is registered and rises
// in the cycle after the last lookup; a backed-up queue delays a result by the
// time the engine spends on older ones. The result is shown for one cycle with
// done high; the receiver cannot stall, so results are never held back.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Writes are allowed only while the block is idle.
// After reset the set memory is cleared one row per cycle, all MAX_SETS rows,
// and busy stays high until that pass is done.
`include "set_assoc_cache_with_prefetch_core_macros.svh"

module set_assoc_cache_with_prefetch_core
    import scp_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    parameter int MAX_PREFETCH = DEF_MAX_PREFETCH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_t                   item,
    output logic                  done,
    output out_t                  result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic clearing;
    logic pop;
    logic q_valid;
    in_t  q_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BLOCK_BITS:     cfg_next.block_bits = cfg_data;
                CFG_SET_BITS:       cfg_next.set_bits = cfg_data;
                CFG_WAYS_USED:      cfg_next.ways_used = cfg_data;
                CFG_LRU_MODE:       cfg_next.lru_mode = cfg_data[0];
                CFG_PREFETCH_COUNT: cfg_next.prefetch_count = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_bits     <= 4'd6;
            cfg_reg.set_bits       <= 4'd0;
            cfg_reg.ways_used      <= 4'd1;
            cfg_reg.lru_mode       <= 1'b0;
            cfg_reg.prefetch_count <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .clearing (clearing),
        .pop      (pop),
        .busy     (busy),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    scp_back #(
        .MAX_SETS     (MAX_SETS),
        .MAX_WAYS     (MAX_WAYS),
        .MAX_PREFETCH (MAX_PREFETCH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    // Every access passes through at least one read and one evaluate state.
    `SCP_ASSERT_NEXT(a_done_spaced, done, !done)
    // A demand hit never issues a memory read.
    `SCP_ASSERT_NOW(a_hit_no_reads, done && result.hit, result.reads_issued == 5'd0)
    // A demand miss issues at least its own fill read.
    `SCP_ASSERT_NOW(a_miss_reads, done && !result.hit, result.reads_issued != 5'd0)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import scp_pkg::*;

    localparam int NSETS = DEF_MAX_SETS;
    localparam int NWAYS = DEF_MAX_WAYS;
    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t item;
    logic done;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    set_assoc_cache_with_prefetch_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Tag-store predictor plus the queue of outcomes still owed by the block.
    class cache_scoreboard;
        logic [ADDR_BITS-1:0] tags [NSETS][NWAYS];
        bit vld [NSETS][NWAYS];
        logic [31:0] stamps [NSETS][NWAYS];
        logic [31:0] stamp_now;
        logic [31:0] hits_n, misses_n, reads_n, writes_n;
        cfg_t cfg;
        out_t owed [$];
        int errors;
        int checked;

        function void clear_state();
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++)
                begin
                    tags[s][w] = '0;
                    vld[s][w] = 0;
                    stamps[s][w] = '0;
                end
            stamp_now = 32'd1;
            hits_n = '0;
            misses_n = '0;
            reads_n = '0;
            writes_n = '0;
            cfg.block_bits = 4'd6;
            cfg.set_bits = 4'd0;
            cfg.ways_used = 4'd1;
            cfg.lru_mode = 1'b0;
            cfg.prefetch_count = 4'd0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BLOCK_BITS: cfg.block_bits = val;
                CFG_SET_BITS: cfg.set_bits = val;
                CFG_WAYS_USED: cfg.ways_used = val;
                CFG_LRU_MODE: cfg.lru_mode = val[0];
                CFG_PREFETCH_COUNT: cfg.prefetch_count = val;
                default: ;
            endcase
        endfunction

        function int blk_shift();
            return (cfg.block_bits > BLOCK_BITS_MAX) ? 12 : int'(cfg.block_bits);
        endfunction

        function int set_shift();
            int sb;
            sb = int'(cfg.set_bits);
            while (sb > 0 && (1 << sb) > NSETS)
                sb--;
            return sb;
        endfunction

        function int way_count();
            if (cfg.ways_used == 0)
                return 1;
            if (cfg.ways_used > NWAYS)
                return NWAYS;
            return int'(cfg.ways_used);
        endfunction

        function void split_addr(logic [ADDR_BITS-1:0] a, output int s,
                                 output logic [ADDR_BITS-1:0] t);
            logic [ADDR_BITS-1:0] blk;
            int sb;
            sb = set_shift();
            blk = a >> blk_shift();
            s = int'(blk & ((48'd1 << sb) - 48'd1)) % NSETS;
            t = blk >> sb;
        endfunction

        function bit probe(int s, logic [ADDR_BITS-1:0] t);
            for (int w = 0; w < way_count(); w++)
                if (vld[s][w] && tags[s][w] == t)
                begin
                    if (cfg.lru_mode)
                        stamps[s][w] = stamp_now;
                    return 1;
                end
            return 0;
        endfunction

        function void allocate(int s, logic [ADDR_BITS-1:0] t);
            int place;
            logic [31:0] oldest;
            place = 0;
            oldest = stamp_now;
            for (int w = 0; w < way_count(); w++)
            begin
                if (!vld[s][w])
                begin
                    place = w;
                    break;
                end
                if (stamps[s][w] < oldest)
                begin
                    oldest = stamps[s][w];
                    place = w;
                end
            end
            tags[s][place] = t;
            stamps[s][place] = stamp_now;
            vld[s][place] = 1;
        endfunction

        function void note_access(in_t acc);
            logic [ADDR_BITS-1:0] a, t;
            int s, npf;
            logic [4:0] issued;
            bit h;
            out_t r;
            a = acc.address;
            issued = '0;
            stamp_now++;
            if (acc.is_write)
                writes_n++;
            split_addr(a, s, t);
            h = probe(s, t);
            if (h)
                hits_n++;
            else
            begin
                misses_n++;
                issued++;
                allocate(s, t);
                npf = (cfg.prefetch_count > DEF_MAX_PREFETCH) ? DEF_MAX_PREFETCH
                                                               : int'(cfg.prefetch_count);
                for (int i = 0; i < npf; i++)
                begin
                    stamp_now++;
                    a = a + (48'd1 << blk_shift());
                    split_addr(a, s, t);
                    if (!probe(s, t))
                    begin
                        issued++;
                        stamp_now++;
                        allocate(s, t);
                    end
                end
            end
            reads_n += 32'(issued);
            r.hit = h;
            r.reads_issued = issued;
            r.total_hits = hits_n;
            r.total_misses = misses_n;
            r.total_reads = reads_n;
            r.total_writes = writes_n;
            owed.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (owed.size() == 0)
            begin
                $error("unexpected result: %h", got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            checked++;
            if (got.hit !== exp.hit)
            begin
                $error("hit: expected %0d, actual %0d", exp.hit, got.hit);
                errors++;
            end
            if (got.reads_issued !== exp.reads_issued)
            begin
                $error("reads_issued: expected %0d, actual %0d",
                       exp.reads_issued, got.reads_issued);
                errors++;
            end
            if (got.total_hits !== exp.total_hits)
            begin
                $error("total_hits: expected %0d, actual %0d", exp.total_hits, got.total_hits);
                errors++;
            end
            if (got.total_misses !== exp.total_misses)
            begin
                $error("total_misses: expected %0d, actual %0d",
                       exp.total_misses, got.total_misses);
                errors++;
            end
            if (got.total_reads !== exp.total_reads)
            begin
                $error("total_reads: expected %0d, actual %0d", exp.total_reads, got.total_reads);
                errors++;
            end
            if (got.total_writes !== exp.total_writes)
            begin
                $error("total_writes: expected %0d, actual %0d",
                       exp.total_writes, got.total_writes);
                errors++;
            end
        endfunction
    endclass

    cache_scoreboard sb;
    int cycles;
    int sent;
    int gap_left;
    logic [ADDR_BITS-1:0] stream_addr;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // The receiver cannot stall, so every strobe is checked at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int bb, int sbits, int ways, int lru, int pf);
        wait_idle();
        write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
        write_reg(CFG_SET_BITS, CFG_DATA_W'(sbits));
        write_reg(CFG_WAYS_USED, CFG_DATA_W'(ways));
        write_reg(CFG_LRU_MODE, CFG_DATA_W'(lru));
        write_reg(CFG_PREFETCH_COUNT, CFG_DATA_W'(pf));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender works in bursts; a gap drops start for some cycles first.
    // start stays high after an accepted transaction until the next call drives it.
    task automatic send_access(logic [ADDR_BITS-1:0] a, logic w);
        if (gap_left == 0 && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(1, 12);
        if (gap_left > 0)
        begin
            start <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        start <= 1'b1;
        item.address <= a;
        item.is_write <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access('{address: a, is_write: w});
        sent++;
    endtask

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        return ADDR_BITS'({$urandom(), $urandom()});
    endfunction

    function automatic logic [ADDR_BITS-1:0] local_addr();
        // Addresses in a narrow window so that tags repeat and sets fill up.
        return {36'h0, 12'($urandom_range(0, 4095))};
    endfunction

    initial
    begin
        sb = new();
        sb.clear_state();
        cycles = 0;
        sent = 0;
        gap_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings, then at the extremes.
        send_access('0, 1'b0);
        send_access('0, 1'b1);
        send_access({ADDR_BITS{1'b1}}, 1'b0);
        send_access(48'h40, 1'b1);
        send_access(48'h80, 1'b0);
        configure(15, 15, 0, 1, 15);
        send_access({ADDR_BITS{1'b1}} - 48'h100, 1'b0);
        send_access('0, 1'b1);
        send_access(48'h1000, 1'b0);
        send_access('0, 1'b0);
        configure(0, 0, 15, 0, 15);
        for (int i = 0; i < 10; i++)
            send_access(48'(i * 3), i[0]);
        configure(12, 8, 8, 1, 0);
        send_access(48'hAAAA_AAAA_AAAA, 1'b1);
        send_access(48'h5555_5555_5555, 1'b0);

        // Random phases with fresh settings; one pause drains everything.
        for (int ph = 0; ph < 15; ph++)
        begin
            configure($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 1), ($urandom_range(0, 3) == 0) ? 15
                      : $urandom_range(0, 4));
            stream_addr = local_addr();
            for (int i = 0; i < 100; i++)
            begin
                if (ph == 5 && i == 50)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (sb.owed.size() != 0)
                        @(posedge clk);
                end
                case ($urandom_range(0, 3))
                    0: send_access(rand_addr(), 1'($urandom_range(0, 1)));
                    1:
                    begin
                        stream_addr = stream_addr + 48'($urandom_range(1, 128));
                        send_access(stream_addr, 1'($urandom_range(0, 1)));
                    end
                    default: send_access(local_addr(), 1'($urandom_range(0, 1)));
                endcase
            end
        end

        wait_idle();
        $display("Covered %0d accesses, %0d results checked, over 18 configuration settings.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
